// ===== hdl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define ASSERT_HOLDS(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)

`endif

`endif

// ===== hdl/crcg_pkg.sv =====
package crcg_pkg;

  localparam int MaxDegree = 32;
  localparam int RemW      = MaxDegree;
  localparam int DegW      = 6;
  localparam int PolyW     = 32;
  localparam int IdxW      = (MaxDegree > 1) ? $clog2(MaxDegree) : 1;
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);
  localparam int TdataW    = 8;

  // configuration register indexes
  localparam logic RegPoly   = 1'b0;
  localparam logic RegDegree = 1'b1;

  localparam logic [PolyW-1:0] PolyReset   = 32'h04C1_1DB7;
  localparam logic [DegW-1:0]  DegreeReset = 6'd32;

  typedef logic [RemW-1:0] rem_t;
  typedef logic [DegW-1:0] deg_t;

  // one accepted message bit, with the remainder after it
  typedef struct packed {
    logic data_bit;
    logic last_bit;
    rem_t rem;
    deg_t degree;
  } entry_t;

  typedef enum logic {
    ST_ECHO,
    ST_CHECK
  } back_state_e;

  // degree zero behaves as one, large degrees saturate
  function automatic deg_t eff_degree(input deg_t d);
    deg_t r;
    r = d;
    if (d == '0) begin
      r = DegW'(1);
    end else if (d > DegW'(MaxDegree)) begin
      r = DegW'(MaxDegree);
    end
    return r;
  endfunction

endpackage

// ===== hdl/crc_codeword_generator.sv =====
// bit-serial crc codeword generator
// slave stream: one message bit per transfer in s_axis_tdata[0], highest
// power first; s_axis_tlast marks the final bit of the message.
// master stream: each message bit is echoed (tuser 0); after the final bit
// the degree check bits follow, most significant first, with tuser 1 and
// tlast on the last check bit only. tdata[0] carries the codeword bit.
// configuration: cfg_we_i writes cfg_data_i to register cfg_addr_i
// (0 generator coefficients below the leading one, 1 degree); write only
// while no message is in flight.
// path: a bit is written into the queue, then loaded into the output register.
// throughput: one bit per cycle on both sides while not stalled; a final
// bit occupies the master side for its echo and the degree check bits, set
// by the one-bit-a-cycle drain of the remainder. a 4-entry queue between
// the lfsr front and the drain logic lets the slave side keep going while
// check bits are sent. a stalled master side holds its transfer; the queue
// fills and then s_axis_tready drops until space frees up.
// reset: remainder, queue and output register clear; registers return to
// polynomial 0x04C11DB7, degree 32.
module crc_codeword_generator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [crcg_pkg::TdataW-1:0] s_axis_tdata,  // [0] data_bit, rest zero
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [crcg_pkg::TdataW-1:0] m_axis_tdata,  // [0] code_bit, rest zero
  output logic                        m_axis_tuser,  // [0] is_check
  output logic                        m_axis_tlast,
  input  logic                        cfg_we_i,
  input  logic                        cfg_addr_i,
  input  logic [crcg_pkg::PolyW-1:0]  cfg_data_i
);

  logic [crcg_pkg::PolyW-1:0] poly_q;
  crcg_pkg::deg_t             degree_q;
  crcg_pkg::entry_t           push_entry, head;
  logic                       push, pop, full, empty, code_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q   <= crcg_pkg::PolyReset;
      degree_q <= crcg_pkg::DegreeReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        crcg_pkg::RegPoly:   poly_q   <= cfg_data_i;
        crcg_pkg::RegDegree: degree_q <= cfg_data_i[crcg_pkg::DegW-1:0];
        default: ;
      endcase
    end
  end

  crcg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata[0]),
    .in_last_i  (s_axis_tlast),
    .poly_i     (poly_q),
    .degree_i   (degree_q),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  crcg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  crcg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_bit_o   (code_bit),
    .out_check_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(crcg_pkg::TdataW-1){1'b0}}, code_bit};

endmodule

// ===== hdl/crcg_front.sv =====
module crcg_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_data_i,
  input  logic                       in_last_i,
  input  logic [crcg_pkg::PolyW-1:0] poly_i,
  input  crcg_pkg::deg_t             degree_i,
  input  logic                       full_i,
  output logic                       push_o,
  output crcg_pkg::entry_t           entry_o
);

  crcg_pkg::rem_t rem_q, rem_d;
  crcg_pkg::rem_t mask, rem_m, rem_n;
  crcg_pkg::deg_t deg;
  logic           fb;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    deg   = crcg_pkg::eff_degree(degree_i);
    mask  = {crcg_pkg::RemW{1'b1}} >> (crcg_pkg::DegW'(crcg_pkg::RemW) - deg);
    rem_m = rem_q & mask;
    fb    = in_data_i ^ rem_m[crcg_pkg::IdxW'(deg - crcg_pkg::DegW'(1))];
    rem_n = (rem_m << 1) & mask;
    if (fb) begin
      rem_n = rem_n ^ (crcg_pkg::RemW'(poly_i) & mask);
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (push_o) begin
      rem_d = in_last_i ? '0 : rem_n;
    end
  end

  assign entry_o = '{data_bit: in_data_i, last_bit: in_last_i, rem: rem_n, degree: deg};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

endmodule

// ===== hdl/crcg_fifo.sv =====
module crcg_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  crcg_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output crcg_pkg::entry_t head_o
);

  crcg_pkg::entry_t                mem_q [crcg_pkg::FifoDepth];
  logic [crcg_pkg::PtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [crcg_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == crcg_pkg::CntW'(crcg_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? crcg_pkg::PtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? crcg_pkg::PtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = crcg_pkg::CntW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = crcg_pkg::CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ===== hdl/crcg_back.sv =====
`include "assert_macros.svh"

module crcg_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  crcg_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_bit_o,
  output logic             out_check_o,
  output logic             out_last_o
);

  crcg_pkg::back_state_e state_q, state_d;
  crcg_pkg::deg_t        cnt_q, cnt_d;
  logic                  valid_q, valid_d;
  logic                  bit_q, bit_d;
  logic                  check_q, check_d;
  logic                  last_q, last_d;
  logic                  load;

  // output register can take a new transfer when empty or being drained
  assign load = !valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      crcg_pkg::ST_ECHO: begin
        if (load && !empty_i && head_i.last_bit) begin
          state_d = crcg_pkg::ST_CHECK;
        end
      end
      crcg_pkg::ST_CHECK: begin
        if (load && cnt_q == crcg_pkg::DegW'(1)) begin
          state_d = crcg_pkg::ST_ECHO;
        end
      end
      default: state_d = crcg_pkg::ST_ECHO;
    endcase
  end

  always_comb begin
    pop_o   = 1'b0;
    cnt_d   = cnt_q;
    valid_d = load ? 1'b0 : valid_q;
    bit_d   = bit_q;
    check_d = check_q;
    last_d  = last_q;
    case (state_q)
      crcg_pkg::ST_ECHO: begin
        if (load && !empty_i) begin
          valid_d = 1'b1;
          bit_d   = head_i.data_bit;
          check_d = 1'b0;
          last_d  = 1'b0;
          cnt_d   = head_i.degree;
          pop_o   = !head_i.last_bit;
        end
      end
      crcg_pkg::ST_CHECK: begin
        if (load) begin
          valid_d = 1'b1;
          bit_d   = head_i.rem[crcg_pkg::IdxW'(cnt_q - crcg_pkg::DegW'(1))];
          check_d = 1'b1;
          last_d  = (cnt_q == crcg_pkg::DegW'(1));
          cnt_d   = crcg_pkg::DegW'(cnt_q - crcg_pkg::DegW'(1));
          pop_o   = (cnt_q == crcg_pkg::DegW'(1));
        end
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crcg_pkg::ST_ECHO;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q   <= bit_d;
    check_q <= check_d;
    last_q  <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_bit_o   = bit_q;
  assign out_check_o = check_q;
  assign out_last_o  = last_q;

  `ASSERT_HOLDS(a_check_cnt_live, clk_i, rst_ni,
                (state_q == crcg_pkg::ST_CHECK) |-> (cnt_q != '0))
  `ASSERT_NEVER(a_check_head_gone, clk_i, rst_ni,
                (state_q == crcg_pkg::ST_CHECK) && empty_i)
  `ASSERT_HOLDS(a_last_is_check, clk_i, rst_ni,
                (valid_q && last_q) |-> check_q)

endmodule
